// ===== hdl/multiset_floor_take_core_macros.svh =====
// Assertion macros for the multiset floor take core.
`ifndef MULTISET_FLOOR_TAKE_CORE_MACROS_SVH
`define MULTISET_FLOOR_TAKE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MFT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mft_pkg.sv =====
// Shared types and codes for the multiset floor take core.
`timescale 1ns / 1ps

package mft_pkg;

	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	// Action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_TAKE   = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN
	} mft_state_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic             exec;   // operation cycle: leaves capture
		logic             upd;    // cells rewrite their values
		logic             take;   // 1 take, 0 insert
		logic [VAL_W-1:0] key;    // insert value or take limit
	} mft_ctl_t;

endpackage

// ===== hdl/mft_cell.sv =====
// One cell of the sorted chain: a stored value, its compare and its shift mux.
`timescale 1ns / 1ps

module mft_cell import mft_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 11
) (
	input  logic             clk,
	input  mft_ctl_t         ctl,
	input  logic [CNT_W-1:0] occ,
	input  logic [VAL_W-1:0] left_val,
	input  logic             left_le,
	input  logic [VAL_W-1:0] right_val,
	input  logic             right_le,
	output logic [VAL_W-1:0] val,
	output logic             le,
	output logic [VAL_W-1:0] leaf
);

	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] val_d;
	logic [VAL_W-1:0] leaf_q;

	// Occupied and not above the key; over the chain this is a prefix
	assign le = (CNT_W'(IDX) < occ) && (val_q <= ctl.key);

	always_comb begin
		val_d = val_q;
		if (ctl.upd) begin
			if (ctl.take) begin
				// at or after the removed entry: pull from the right
				if (!right_le) begin
					val_d = right_val;
				end
			end else begin
				// above the key: open a gap, first such cell takes the key
				if (!le) begin
					val_d = left_le ? ctl.key : left_val;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		if (ctl.exec) begin
			leaf_q <= (ctl.take && le && !right_le) ? val_q : '0;
		end
	end

	assign val  = val_q;
	assign leaf = leaf_q;

endmodule

// ===== hdl/mft_or_tree.sv =====
// Pipelined OR tree that collects the one removed value from the cell row.
`timescale 1ns / 1ps

module mft_or_tree import mft_pkg::*; #(
	parameter int LEAVES = 1024
) (
	input  logic             clk,
	input  logic [VAL_W-1:0] leaf [LEAVES],
	output logic [VAL_W-1:0] root
);

	localparam int LOG = $clog2(LEAVES);
	localparam int PAD = 1 << LOG;

	// heap layout: node 0 is the root, leaves start at PAD-1
	logic [VAL_W-1:0] node [2*PAD-1];

	genvar i;
	generate
		for (i = 0; i < PAD; i++) begin : g_leaf
			if (i < LEAVES) begin : g_used
				assign node[PAD-1+i] = leaf[i];
			end else begin : g_pad
				assign node[PAD-1+i] = '0;
			end
		end

		for (i = 0; i < PAD - 1; i++) begin : g_node
			localparam int D = $clog2(i + 2) - 1;
			if (((LOG - D) % 4) == 0) begin : g_reg
				logic [VAL_W-1:0] or_q;
				always_ff @(posedge clk) begin
					or_q <= node[2*i+1] | node[2*i+2];
				end
				assign node[i] = or_q;
			end else begin : g_comb
				assign node[i] = node[2*i+1] | node[2*i+2];
			end
		end
	endgenerate

	assign root = node[0];

endmodule

// ===== hdl/multiset_floor_take_core.sv =====
// Top level of the multiset floor take core: controller, cell row, OR tree.
//
// Holds up to CAPACITY unsigned 32-bit values in ascending order in a row of
// cells. Request channel (req_valid/req_stall, fields action and value):
// action insert adds value; action take removes one copy of the largest
// stored value not above value. Every item yields one response on the
// rsp_valid/rsp_stall channel with status (ok, none, full) and taken.
// An item is moved when valid is high and stall is low at a clock edge.
// Each item passes from accept to the response register through a register
// for the request, an execute step in which all cells compare in parallel
// and shift, and the registered stages of the OR tree that collect the
// removed value. One item is in work at a time; req_stall is low only when
// idle, so a new item is not taken before the last one has reached the
// output register.
// The response sits in an output register, so the next item can be taken
// while a response waits; if rsp_stall holds, the finished item waits in
// the tree until the output register frees.
// arst_n clears the occupancy and all control state; cell contents are
// left as they are and are never read before written.
`timescale 1ns / 1ps

`include "multiset_floor_take_core_macros.svh"

module multiset_floor_take_core import mft_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              action,
	input  logic [VAL_W-1:0]  value,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [STAT_W-1:0] status,
	output logic [VAL_W-1:0]  taken
);

	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int TREE_REGS = $clog2(CAPACITY) / 4;
	localparam int DR_W      = $clog2(TREE_REGS + 2);

	// control
	mft_state_t        state_q, state_d;
	logic [CNT_W-1:0]  occ_q;
	logic [DR_W-1:0]   cnt_q;
	logic              action_q;
	logic [VAL_W-1:0]  key_q;
	logic [STAT_W-1:0] stat_q;

	// output register
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [VAL_W-1:0]  taken_q;

	logic      accept;
	logic      exec;
	logic      tree_done;
	logic      out_load;
	logic      full;
	logic      found;
	mft_ctl_t  ctl;

	// cell row
	logic [VAL_W-1:0] cell_val  [CAPACITY];
	logic             cell_le   [CAPACITY];
	logic [VAL_W-1:0] cell_leaf [CAPACITY];
	logic [VAL_W-1:0] root;

	assign accept = req_valid && !req_stall;
	assign full   = (occ_q == CNT_W'(CAPACITY));
	assign found  = cell_le[0];   // prefix: any match means cell 0 matches

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs of the controller
	always_comb begin
		req_stall = 1'b1;
		exec      = 1'b0;
		tree_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
			end
			S_EXEC: begin
				exec = 1'b1;
			end
			S_DRAIN: begin
				tree_done = (cnt_q == '0);
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	assign out_load = tree_done && (!out_valid_q || !rsp_stall);

	always_comb begin
		ctl.exec = exec;
		ctl.take = (action_q == ACT_TAKE);
		ctl.key  = key_q;
		ctl.upd  = exec && ((action_q == ACT_TAKE) ? found : !full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.upd) begin
				occ_q <= ctl.take ? occ_q - 1'b1 : occ_q + 1'b1;
			end
			if (exec) begin
				cnt_q <= DR_W'(TREE_REGS);
			end else if (state_q == S_DRAIN && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			key_q    <= value;
		end
		if (exec) begin
			if (action_q == ACT_TAKE) begin
				stat_q <= found ? ST_OK : ST_NONE;
			end else begin
				stat_q <= full ? ST_FULL : ST_OK;
			end
		end
		if (out_load) begin
			status_q <= stat_q;
			taken_q  <= root;
		end
	end

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [VAL_W-1:0] lv, rv;
			logic             lle, rle;
			if (i == 0) begin : g_first
				assign lv  = key_q;
				assign lle = 1'b1;
			end else begin : g_left
				assign lv  = cell_val[i-1];
				assign lle = cell_le[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign rv  = cell_val[i];
				assign rle = 1'b0;
			end else begin : g_right
				assign rv  = cell_val[i+1];
				assign rle = cell_le[i+1];
			end
			mft_cell #(
				.IDX   (i),
				.CNT_W (CNT_W)
			) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.occ       (occ_q),
				.left_val  (lv),
				.left_le   (lle),
				.right_val (rv),
				.right_le  (rle),
				.val       (cell_val[i]),
				.le        (cell_le[i]),
				.leaf      (cell_leaf[i])
			);
		end
	endgenerate

	mft_or_tree #(
		.LEAVES (CAPACITY)
	) u_tree (
		.clk  (clk),
		.leaf (cell_leaf),
		.root (root)
	);

	assign rsp_valid = out_valid_q;
	assign status    = status_q;
	assign taken     = taken_q;

	// checks
	`MFT_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= CNT_W'(CAPACITY), "occupancy above capacity")
	`MFT_ASSERT_NEXT(a_accept_exec, accept, state_q == S_EXEC, "accepted item did not start")
	`MFT_ASSERT_NEXT(a_insert_grow, exec && !ctl.take && !full, occ_q == $past(occ_q) + 1'b1, "insert did not grow occupancy")
	`MFT_ASSERT_NOW(a_none_zero, rsp_valid && status == ST_NONE, taken == '0, "empty take returned a value")

endmodule
